// ----- hdl/x86d_pkg.sv -----
// ----------------------------------------------------------------------------
// x86d_pkg
// Shared types, opcode constants and instruction kinds for the x86 subset
// instruction decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package x86d_pkg;

    // Window geometry and field widths.
    localparam int WINDOW_SIZE  = 8;
    localparam int WINDOW_W     = 64;
    localparam int VALID_W      = 4;
    localparam int AVAIL_W      = 5;
    localparam int OFFSET_W     = 32;
    localparam int VALUE_W      = 32;
    localparam int LENGTH_W     = 4;
    localparam int BYTE_W       = 8;
    localparam int KIND_W       = 4;
    localparam int S_TDATA_W    = 104;
    localparam int M_TDATA_W    = 48;

    // Instruction kinds as they appear on the result channel.
    typedef enum logic [KIND_W-1:0] {
        KIND_NOP  = 4'd0,
        KIND_RET  = 4'd1,
        KIND_PUSH = 4'd2,
        KIND_POP  = 4'd3,
        KIND_XCHG = 4'd4,
        KIND_INC  = 4'd5,
        KIND_DEC  = 4'd6,
        KIND_CLRA = 4'd7,
        KIND_CLRC = 4'd8,
        KIND_MOVA = 4'd9,
        KIND_MOVC = 4'd10,
        KIND_JMP  = 4'd11,
        KIND_JE   = 4'd12,
        KIND_CMP  = 4'd13,
        KIND_JUNK = 4'd14,
        KIND_RAW  = 4'd15
    } kind_t;

    // Opcode and operand bytes recognised by the decoder.
    localparam logic [7:0] OP_NOP       = 8'h90;
    localparam logic [7:0] OP_OPSIZE    = 8'h66;
    localparam logic [7:0] OP_ESCAPE    = 8'h0F;
    localparam logic [7:0] OP_NOPL      = 8'h1F;
    localparam logic [7:0] OP_RET       = 8'hC3;
    localparam logic [7:0] OP_PUSH_RAX  = 8'h50;
    localparam logic [7:0] OP_POP_RAX   = 8'h58;
    localparam logic [7:0] OP_PUSH_RCX  = 8'h51;
    localparam logic [7:0] OP_POP_RCX   = 8'h59;
    localparam logic [7:0] OP_REX_W     = 8'h48;
    localparam logic [7:0] OP_XCHG      = 8'h87;
    localparam logic [7:0] OP_GRP5      = 8'hFF;
    localparam logic [7:0] OP_XOR       = 8'h31;
    localparam logic [7:0] OP_SUB       = 8'h29;
    localparam logic [7:0] OP_MOV_RM    = 8'hC7;
    localparam logic [7:0] OP_MOV_EAX   = 8'hB8;
    localparam logic [7:0] OP_MOV_ECX   = 8'hB9;
    localparam logic [7:0] OP_JMP8      = 8'hEB;
    localparam logic [7:0] OP_JMP32     = 8'hE9;
    localparam logic [7:0] OP_JE8       = 8'h74;
    localparam logic [7:0] OP_JE32      = 8'h84;
    localparam logic [7:0] OP_GRP1_IB   = 8'h83;
    localparam logic [7:0] OP_GRP1_ID   = 8'h81;
    localparam logic [7:0] OP_PUSH_IB   = 8'h6A;
    localparam logic [7:0] OP_LEA       = 8'h8D;
    localparam logic [7:0] MODRM_RAX    = 8'hC0;
    localparam logic [7:0] MODRM_RCX    = 8'hC1;
    localparam logic [7:0] MODRM_RCX_RCX = 8'hC9;
    localparam logic [7:0] MODRM_DEC    = 8'hC8;
    localparam logic [7:0] MODRM_CMP_RCX = 8'hF9;
    localparam logic [7:0] MODRM_SIB_D8 = 8'h64;
    localparam logic [7:0] SIB_RSP      = 8'h24;
    localparam logic [7:0] BYTE_ZERO    = 8'h00;

    // ModRM field codes.
    localparam logic [1:0] MOD_IND      = 2'd0;
    localparam logic [1:0] MOD_DISP8    = 2'd1;
    localparam logic [1:0] MOD_DISP32   = 2'd2;
    localparam logic [1:0] MOD_REG      = 2'd3;
    localparam logic [2:0] RM_SIB       = 3'd4;
    localparam logic [2:0] RM_RIP       = 3'd5;

    // One decoded instruction.
    typedef struct packed {
        kind_t                kind;
        logic [VALUE_W-1:0]   value;
        logic [LENGTH_W-1:0]  length;
        logic [BYTE_W-1:0]    raw_byte;
    } decode_t;

endpackage

`default_nettype wire

// ----- hdl/x86_subset_insn_decoder.sv -----
// ----------------------------------------------------------------------------
// x86_subset_insn_decoder
// Classifies one instruction of a small x86 subset per code window.
// ----------------------------------------------------------------------------
// Usage:
//   The slave channel carries one code window per transaction: eight code
//   bytes, the count of bytes that exist before the end of the buffer and the
//   buffer offset of the first byte. The master channel returns one decoded
//   instruction per window: its kind on m_tuser, and its value, length and
//   first raw byte on m_tdata.
//   Each window passes through an input register, the classifier logic and a
//   result register. An accepted window is held in the input register, and its
//   result is moved into the result register once that register is free. One
//   window is accepted in every cycle while the receiver does not stall; the
//   rate is set by the single pass of byte compares and one 32-bit target
//   adder between the two registers.
//   When the receiver stalls, the result register holds its transaction and
//   the input register may still take one more window; once both are full,
//   s_tready falls until the master side moves again.
//   A synchronous active-low reset empties both registers; no result is shown
//   until a new window has been accepted.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module x86_subset_insn_decoder (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // Slave tdata, from bit 0: window_bytes[63:0], valid_bytes[3:0],
    // byte_offset[31:0], zero padding.
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [x86d_pkg::S_TDATA_W-1:0]     s_tdata,
    // Master tdata, from bit 0: insn_value[31:0], insn_length[3:0],
    // raw_byte[7:0], zero padding.
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [x86d_pkg::M_TDATA_W-1:0]          m_tdata,
    // Master tuser, from bit 0: insn_kind[3:0].
    output logic [x86d_pkg::KIND_W-1:0]             m_tuser
);

    localparam int WIN_LO   = 0;
    localparam int VALID_LO = WIN_LO + x86d_pkg::WINDOW_W;
    localparam int OFF_LO   = VALID_LO + x86d_pkg::VALID_W;
    localparam int USED_M_W = x86d_pkg::VALUE_W + x86d_pkg::LENGTH_W + x86d_pkg::BYTE_W;

    logic                              in_valid_reg, in_valid_next;
    logic [x86d_pkg::WINDOW_W-1:0]     window_reg;
    logic [x86d_pkg::VALID_W-1:0]      count_reg;
    logic [x86d_pkg::OFFSET_W-1:0]     offset_reg;
    logic                              out_valid_reg, out_valid_next;
    x86d_pkg::decode_t                 out_reg;
    x86d_pkg::decode_t                 decoded;
    logic                              advance;
    logic                              s_fire;

    // The result register can take a new value when it is empty or is being
    // drained this cycle; the input register follows it.
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = advance ? in_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            window_reg <= s_tdata[WIN_LO +: x86d_pkg::WINDOW_W];
            count_reg  <= s_tdata[VALID_LO +: x86d_pkg::VALID_W];
            offset_reg <= s_tdata[OFF_LO +: x86d_pkg::OFFSET_W];
        end
        if (advance && in_valid_reg) begin
            out_reg <= decoded;
        end
    end

    x86d_decode u_decode (
        .window_bytes (window_reg),
        .valid_bytes  (count_reg),
        .byte_offset  (offset_reg),
        .result       (decoded)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tdata  = {{(x86d_pkg::M_TDATA_W-USED_M_W){1'b0}},
                       out_reg.raw_byte, out_reg.length, out_reg.value};

endmodule

`default_nettype wire

// ----- hdl/x86d_decode.sv -----
// ----------------------------------------------------------------------------
// x86d_decode
// Combinational classifier: matches one instruction of the subset at the
// start of the window and forms its kind, length, value and raw byte.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module x86d_decode (
    input  wire logic [x86d_pkg::WINDOW_W-1:0] window_bytes,
    input  wire logic [x86d_pkg::VALID_W-1:0]  valid_bytes,
    input  wire logic [x86d_pkg::OFFSET_W-1:0] byte_offset,
    output x86d_pkg::decode_t                  result
);

    logic [7:0]                        b0, b1, b2, b3, b4;
    logic [x86d_pkg::AVAIL_W-1:0]      avail;
    logic [1:0]                        modrm_mod;
    logic [2:0]                        modrm_rm;
    logic [x86d_pkg::LENGTH_W-1:0]     nopl_len;
    logic [x86d_pkg::VALUE_W-1:0]      imm1, imm2, imm3;
    x86d_pkg::kind_t                   kind;
    logic [x86d_pkg::LENGTH_W-1:0]     len;
    logic [x86d_pkg::VALUE_W-1:0]      value;
    logic                              is_branch;

    assign b0 = window_bytes[7:0];
    assign b1 = window_bytes[15:8];
    assign b2 = window_bytes[23:16];
    assign b3 = window_bytes[31:24];
    assign b4 = window_bytes[39:32];

    assign imm1 = window_bytes[39:8];
    assign imm2 = window_bytes[47:16];
    assign imm3 = window_bytes[55:24];

    assign modrm_mod = b2[7:6];
    assign modrm_rm  = b2[2:0];

    // A count of zero is taken as one byte; counts above the window saturate.
    always_comb begin
        if (valid_bytes == '0) begin
            avail = x86d_pkg::AVAIL_W'(1);
        end else if ({1'b0, valid_bytes} > x86d_pkg::AVAIL_W'(x86d_pkg::WINDOW_SIZE)) begin
            avail = x86d_pkg::AVAIL_W'(x86d_pkg::WINDOW_SIZE);
        end else begin
            avail = {1'b0, valid_bytes};
        end
    end

    // Length of the 0F 1F multi-byte nop from its ModRM byte.
    always_comb begin
        nopl_len = x86d_pkg::LENGTH_W'(2);
        if (avail >= x86d_pkg::AVAIL_W'(3)) begin
            nopl_len = x86d_pkg::LENGTH_W'(3);
            if (modrm_mod != x86d_pkg::MOD_REG) begin
                if (modrm_rm == x86d_pkg::RM_SIB) begin
                    nopl_len = nopl_len + x86d_pkg::LENGTH_W'(1);
                end
                if (modrm_mod == x86d_pkg::MOD_DISP8) begin
                    nopl_len = nopl_len + x86d_pkg::LENGTH_W'(1);
                end
                if (modrm_mod == x86d_pkg::MOD_DISP32) begin
                    nopl_len = nopl_len + x86d_pkg::LENGTH_W'(4);
                end
                if (modrm_mod == x86d_pkg::MOD_IND && modrm_rm == x86d_pkg::RM_RIP) begin
                    nopl_len = nopl_len + x86d_pkg::LENGTH_W'(4);
                end
            end
        end
    end

    // Priority chain: the first rule that matches wins.
    always_comb begin
        kind      = x86d_pkg::KIND_RAW;
        len       = x86d_pkg::LENGTH_W'(1);
        value     = '0;
        is_branch = 1'b0;
        if (b0 == x86d_pkg::OP_NOP) begin
            kind = x86d_pkg::KIND_NOP;
        end else if (b0 == x86d_pkg::OP_OPSIZE && avail >= 5'd2 && b1 == x86d_pkg::OP_NOP) begin
            kind = x86d_pkg::KIND_NOP;
            len  = x86d_pkg::LENGTH_W'(2);
        end else if (b0 == x86d_pkg::OP_ESCAPE && avail >= 5'd2 && b1 == x86d_pkg::OP_NOPL
                     && {1'b0, nopl_len} <= avail) begin
            kind = x86d_pkg::KIND_NOP;
            len  = nopl_len;
        end else if (b0 == x86d_pkg::OP_RET) begin
            kind = x86d_pkg::KIND_RET;
        end else if (b0 == x86d_pkg::OP_PUSH_RAX) begin
            kind = x86d_pkg::KIND_PUSH;
        end else if (b0 == x86d_pkg::OP_POP_RAX) begin
            kind = x86d_pkg::KIND_POP;
        end else if (b0 == x86d_pkg::OP_REX_W && avail >= 5'd3 && b1 == x86d_pkg::OP_XCHG
                     && b2 == x86d_pkg::MODRM_RAX) begin
            kind = x86d_pkg::KIND_XCHG;
            len  = x86d_pkg::LENGTH_W'(3);
        end else if (b0 == x86d_pkg::OP_XCHG && avail >= 5'd2 && b1 == x86d_pkg::MODRM_RAX) begin
            kind = x86d_pkg::KIND_XCHG;
            len  = x86d_pkg::LENGTH_W'(2);
        end else if (b0 == x86d_pkg::OP_REX_W && avail >= 5'd3 && b1 == x86d_pkg::OP_GRP5
                     && b2 == x86d_pkg::MODRM_RAX) begin
            kind = x86d_pkg::KIND_INC;
            len  = x86d_pkg::LENGTH_W'(3);
        end else if (b0 == x86d_pkg::OP_REX_W && avail >= 5'd3 && b1 == x86d_pkg::OP_GRP5
                     && b2 == x86d_pkg::MODRM_DEC) begin
            kind = x86d_pkg::KIND_DEC;
            len  = x86d_pkg::LENGTH_W'(3);
        end else if (b0 == x86d_pkg::OP_REX_W && avail >= 5'd3
                     && (b1 inside {x86d_pkg::OP_XOR, x86d_pkg::OP_SUB})
                     && b2 == x86d_pkg::MODRM_RAX) begin
            kind = x86d_pkg::KIND_CLRA;
            len  = x86d_pkg::LENGTH_W'(3);
        end else if (b0 == x86d_pkg::OP_REX_W && avail >= 5'd3
                     && (b1 inside {x86d_pkg::OP_XOR, x86d_pkg::OP_SUB})
                     && b2 == x86d_pkg::MODRM_RCX_RCX) begin
            kind = x86d_pkg::KIND_CLRC;
            len  = x86d_pkg::LENGTH_W'(3);
        end else if (b0 == x86d_pkg::OP_REX_W && avail >= 5'd7 && b1 == x86d_pkg::OP_MOV_RM
                     && b2 == x86d_pkg::MODRM_RAX) begin
            kind  = x86d_pkg::KIND_MOVA;
            len   = x86d_pkg::LENGTH_W'(7);
            value = imm3;
        end else if (b0 == x86d_pkg::OP_REX_W && avail >= 5'd7 && b1 == x86d_pkg::OP_MOV_RM
                     && b2 == x86d_pkg::MODRM_RCX) begin
            kind  = x86d_pkg::KIND_MOVC;
            len   = x86d_pkg::LENGTH_W'(7);
            value = imm3;
        end else if (b0 == x86d_pkg::OP_XOR && avail >= 5'd2 && b1 == x86d_pkg::MODRM_RAX) begin
            kind = x86d_pkg::KIND_CLRA;
            len  = x86d_pkg::LENGTH_W'(2);
        end else if (b0 == x86d_pkg::OP_XOR && avail >= 5'd2
                     && b1 == x86d_pkg::MODRM_RCX_RCX) begin
            kind = x86d_pkg::KIND_CLRC;
            len  = x86d_pkg::LENGTH_W'(2);
        end else if (b0 == x86d_pkg::OP_MOV_EAX && avail >= 5'd5) begin
            kind  = x86d_pkg::KIND_MOVA;
            len   = x86d_pkg::LENGTH_W'(5);
            value = imm1;
        end else if (b0 == x86d_pkg::OP_MOV_ECX && avail >= 5'd5) begin
            kind  = x86d_pkg::KIND_MOVC;
            len   = x86d_pkg::LENGTH_W'(5);
            value = imm1;
        end else if (b0 == x86d_pkg::OP_JMP8 && avail >= 5'd2) begin
            kind      = x86d_pkg::KIND_JMP;
            len       = x86d_pkg::LENGTH_W'(2);
            value     = {{24{b1[7]}}, b1};
            is_branch = 1'b1;
        end else if (b0 == x86d_pkg::OP_JMP32 && avail >= 5'd5) begin
            kind      = x86d_pkg::KIND_JMP;
            len       = x86d_pkg::LENGTH_W'(5);
            value     = imm1;
            is_branch = 1'b1;
        end else if (b0 == x86d_pkg::OP_JE8 && avail >= 5'd2) begin
            kind      = x86d_pkg::KIND_JE;
            len       = x86d_pkg::LENGTH_W'(2);
            value     = {{24{b1[7]}}, b1};
            is_branch = 1'b1;
        end else if (b0 == x86d_pkg::OP_ESCAPE && avail >= 5'd6 && b1 == x86d_pkg::OP_JE32) begin
            kind      = x86d_pkg::KIND_JE;
            len       = x86d_pkg::LENGTH_W'(6);
            value     = imm2;
            is_branch = 1'b1;
        end else if (b0 == x86d_pkg::OP_GRP1_IB && avail >= 5'd3
                     && b1 == x86d_pkg::MODRM_CMP_RCX) begin
            kind  = x86d_pkg::KIND_CMP;
            len   = x86d_pkg::LENGTH_W'(3);
            value = {{24{b2[7]}}, b2};
        end else if (b0 == x86d_pkg::OP_GRP1_ID && avail >= 5'd6
                     && b1 == x86d_pkg::MODRM_CMP_RCX) begin
            kind  = x86d_pkg::KIND_CMP;
            len   = x86d_pkg::LENGTH_W'(6);
            value = imm2;
        end else if (b0 == x86d_pkg::OP_PUSH_IB && avail >= 5'd3
                     && b2 == x86d_pkg::OP_POP_RAX) begin
            len = x86d_pkg::LENGTH_W'(3);
            if (b1 == x86d_pkg::BYTE_ZERO) begin
                kind = x86d_pkg::KIND_CLRA;
            end else begin
                kind  = x86d_pkg::KIND_MOVA;
                value = {{24{b1[7]}}, b1};
            end
        end else if (b0 == x86d_pkg::OP_PUSH_RCX && avail >= 5'd2
                     && b1 == x86d_pkg::OP_POP_RCX) begin
            kind = x86d_pkg::KIND_JUNK;
            len  = x86d_pkg::LENGTH_W'(2);
        end else if (b0 == x86d_pkg::OP_REX_W && avail >= 5'd3 && b1 == x86d_pkg::OP_LEA
                     && b2 == x86d_pkg::BYTE_ZERO) begin
            kind = x86d_pkg::KIND_JUNK;
            len  = x86d_pkg::LENGTH_W'(3);
        end else if (b0 == x86d_pkg::OP_REX_W && avail >= 5'd5 && b1 == x86d_pkg::OP_LEA
                     && b2 == x86d_pkg::MODRM_SIB_D8 && b3 == x86d_pkg::SIB_RSP
                     && b4 == x86d_pkg::BYTE_ZERO) begin
            kind = x86d_pkg::KIND_JUNK;
            len  = x86d_pkg::LENGTH_W'(5);
        end
    end

    // Branches report the absolute target, wrapped to 32 bits.
    always_comb begin
        result.kind     = kind;
        result.length   = len;
        result.raw_byte = (kind == x86d_pkg::KIND_RAW) ? b0 : '0;
        if (is_branch) begin
            result.value = byte_offset + {{(x86d_pkg::VALUE_W-x86d_pkg::LENGTH_W){1'b0}}, len}
                           + value;
        end else begin
            result.value = value;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/x86d_checker.sv -----
// ----------------------------------------------------------------------------
// x86d_checker
// Port-level checks on the decoder's result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module x86d_checker (
    input wire logic                           aclk,
    input wire logic                           aresetn,
    input wire logic                           m_tvalid,
    input wire logic                           m_tready,
    input wire logic [x86d_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic [x86d_pkg::KIND_W-1:0]    m_tuser
);

    // A stalled result keeps its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // Lengths lie between one and eight bytes, and a raw item is one byte.
    a_length: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[35:32] != 4'd0 && m_tdata[35:32] <= 4'd8
                     && (m_tuser != x86d_pkg::KIND_RAW || m_tdata[35:32] == 4'd1))
        else $error("bad instruction length");

    // Only immediates, comparisons and branches carry a value.
    a_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != x86d_pkg::KIND_MOVA && m_tuser != x86d_pkg::KIND_MOVC
        && m_tuser != x86d_pkg::KIND_JMP && m_tuser != x86d_pkg::KIND_JE
        && m_tuser != x86d_pkg::KIND_CMP |-> m_tdata[31:0] == 32'd0)
        else $error("value on a kind without one");

    // The raw byte is shown only for raw items.
    a_raw: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != x86d_pkg::KIND_RAW |-> m_tdata[43:36] == 8'd0)
        else $error("raw byte on a decoded instruction");

    // Reset empties the result register.
    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind x86_subset_insn_decoder x86d_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
